FILE: hw/rtl/biou_pkg.sv
// Shared width constants for the box intersection-over-union pipeline.
`timescale 1ns / 1ps

package biou_pkg;

    // Doubled-unit edges (2*center +/- size) need this many bits over the coordinate width,
    // sign included.
    localparam int unsigned EDGE_XB = 3;

    // Intersection area of two clamped extents of COORD_BITS+1 bits each.
    localparam int unsigned NUM_XB = 2;

    // Union area: four times the sum of two box areas, minus the intersection.
    localparam int unsigned DEN_XB = 3;

    // Box areas are scaled by four to match the doubled units of the intersection.
    localparam int unsigned AREA_SHIFT = 2;

endpackage

FILE: hw/rtl/biou_pair_if.sv
// Stream interface that carries one pair of boxes per word.
`timescale 1ns / 1ps

interface biou_pair_if #(
    parameter int unsigned COORD_BITS = 16
) ();
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] a_center_x;
    logic [COORD_BITS-1:0] a_center_y;
    logic [COORD_BITS-1:0] a_width;
    logic [COORD_BITS-1:0] a_height;
    logic [COORD_BITS-1:0] b_center_x;
    logic [COORD_BITS-1:0] b_center_y;
    logic [COORD_BITS-1:0] b_width;
    logic [COORD_BITS-1:0] b_height;

    modport source (
        output valid, a_center_x, a_center_y, a_width, a_height,
        output b_center_x, b_center_y, b_width, b_height,
        input  ready
    );

    modport sink (
        input  valid, a_center_x, a_center_y, a_width, a_height,
        input  b_center_x, b_center_y, b_width, b_height,
        output ready
    );
endinterface

FILE: hw/rtl/biou_frac_if.sv
// Stream interface that carries one intersection/union area pair per word.
`timescale 1ns / 1ps

interface biou_frac_if #(
    parameter int unsigned NUM_W = 34,
    parameter int unsigned DEN_W = 35
) ();
    logic             valid;
    logic             ready;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;

    modport source (output valid, num, den, input ready);
    modport sink   (input valid, num, den, output ready);
endinterface

FILE: hw/rtl/biou_iou_if.sv
// Stream interface that carries one intersection-over-union result per word.
`timescale 1ns / 1ps

interface biou_iou_if #(
    parameter int unsigned IOU_FRAC_BITS = 16
) ();
    logic                   valid;
    logic                   ready;
    logic [IOU_FRAC_BITS:0] iou;

    modport source (output valid, iou, input ready);
    modport sink   (input valid, iou, output ready);
endinterface

FILE: hw/rtl/biou_geom.sv
// Four-stage front end: box edges, overlap extents, area products and union area.
`timescale 1ns / 1ps

module biou_geom #(
    parameter int unsigned COORD_BITS = 16,
    parameter int unsigned NUM_W      = 34,
    parameter int unsigned DEN_W      = 35
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    biou_pair_if.sink      i_pair,
    biou_frac_if.source    o_frac
);
    import biou_pkg::*;

    localparam int unsigned C  = COORD_BITS;
    localparam int unsigned EW = C + EDGE_XB;
    localparam int unsigned AW = 2 * C;

    // Stage valid bits and advance enables.
    logic r_v1, r_v2, r_v3, r_v4;
    logic w_adv1, w_adv2, w_adv3, w_adv4;

    // Stage 1 registers: edges in doubled units and the sizes.
    logic signed [EW-1:0] r_lo_ax, r_hi_ax, r_lo_bx, r_hi_bx;
    logic signed [EW-1:0] r_lo_ay, r_hi_ay, r_lo_by, r_hi_by;
    logic [C-1:0]         r_aw1, r_ah1, r_bw1, r_bh1;

    // Stage 2 registers: clamped overlap extents and the sizes.
    logic [C:0]           r_hx, r_vy;
    logic [C-1:0]         r_aw2, r_ah2, r_bw2, r_bh2;

    // Stage 3 registers: intersection and box areas.
    logic [NUM_W-1:0]     r_inter;
    logic [AW-1:0]        r_aa, r_ab;
    logic                 r_zero3;

    // Stage 4 registers: numerator and denominator for the divider.
    logic [NUM_W-1:0]     r_num;
    logic [DEN_W-1:0]     r_den;

    // Stage 2 combinational terms.
    logic signed [EW-1:0] w_min_hx, w_max_lx, w_min_hy, w_max_ly;
    logic [EW:0]          w_dx, w_dy;
    logic                 w_any_neg;

    // Stage 4 combinational terms.
    logic [DEN_W-1:0]     w_area_sum, w_union;

    // A stage moves when it is empty or the stage after it moves.
    assign w_adv4       = !r_v4 || o_frac.ready;
    assign w_adv3       = !r_v3 || w_adv4;
    assign w_adv2       = !r_v2 || w_adv3;
    assign w_adv1       = !r_v1 || w_adv2;
    assign i_pair.ready = w_adv1;

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_adv1) r_v1 <= i_pair.valid;
            if (w_adv2) r_v2 <= r_v1;
            if (w_adv3) r_v3 <= r_v2;
            if (w_adv4) r_v4 <= r_v3;
        end
    end

    // Stage 1: low edge is 2*center - size, high edge is 2*center + size.
    always_ff @(posedge i_clk) begin
        if (w_adv1 && i_pair.valid) begin
            r_lo_ax <= $signed({{(EW-C-1){1'b0}}, i_pair.a_center_x, 1'b0})
                     - $signed({{(EW-C){1'b0}}, i_pair.a_width});
            r_hi_ax <= $signed({{(EW-C-1){1'b0}}, i_pair.a_center_x, 1'b0})
                     + $signed({{(EW-C){1'b0}}, i_pair.a_width});
            r_lo_bx <= $signed({{(EW-C-1){1'b0}}, i_pair.b_center_x, 1'b0})
                     - $signed({{(EW-C){1'b0}}, i_pair.b_width});
            r_hi_bx <= $signed({{(EW-C-1){1'b0}}, i_pair.b_center_x, 1'b0})
                     + $signed({{(EW-C){1'b0}}, i_pair.b_width});
            r_lo_ay <= $signed({{(EW-C-1){1'b0}}, i_pair.a_center_y, 1'b0})
                     - $signed({{(EW-C){1'b0}}, i_pair.a_height});
            r_hi_ay <= $signed({{(EW-C-1){1'b0}}, i_pair.a_center_y, 1'b0})
                     + $signed({{(EW-C){1'b0}}, i_pair.a_height});
            r_lo_by <= $signed({{(EW-C-1){1'b0}}, i_pair.b_center_y, 1'b0})
                     - $signed({{(EW-C){1'b0}}, i_pair.b_height});
            r_hi_by <= $signed({{(EW-C-1){1'b0}}, i_pair.b_center_y, 1'b0})
                     + $signed({{(EW-C){1'b0}}, i_pair.b_height});
            r_aw1   <= i_pair.a_width;
            r_ah1   <= i_pair.a_height;
            r_bw1   <= i_pair.b_width;
            r_bh1   <= i_pair.b_height;
        end
    end

    // Stage 2: overlap extent is the smaller high edge minus the larger low edge.
    always_comb begin
        w_min_hx  = (r_hi_ax < r_hi_bx) ? r_hi_ax : r_hi_bx;
        w_max_lx  = (r_lo_ax > r_lo_bx) ? r_lo_ax : r_lo_bx;
        w_min_hy  = (r_hi_ay < r_hi_by) ? r_hi_ay : r_hi_by;
        w_max_ly  = (r_lo_ay > r_lo_by) ? r_lo_ay : r_lo_by;
        w_dx      = {w_min_hx[EW-1], w_min_hx} - {w_max_lx[EW-1], w_max_lx};
        w_dy      = {w_min_hy[EW-1], w_min_hy} - {w_max_ly[EW-1], w_max_ly};
        w_any_neg = w_dx[EW] || w_dy[EW];
    end

    // A negative extent on either axis means no overlap at all.
    always_ff @(posedge i_clk) begin
        if (w_adv2 && r_v1) begin
            r_hx  <= w_any_neg ? '0 : w_dx[C:0];
            r_vy  <= w_any_neg ? '0 : w_dy[C:0];
            r_aw2 <= r_aw1;
            r_ah2 <= r_ah1;
            r_bw2 <= r_bw1;
            r_bh2 <= r_bh1;
        end
    end

    // Stage 3: area products. The union is zero only when both boxes are flat.
    always_ff @(posedge i_clk) begin
        if (w_adv3 && r_v2) begin
            r_inter <= {{(NUM_W-C-1){1'b0}}, r_hx} * {{(NUM_W-C-1){1'b0}}, r_vy};
            r_aa    <= r_aw2 * r_ah2;
            r_ab    <= r_bw2 * r_bh2;
            r_zero3 <= (r_aw2 == '0 || r_ah2 == '0) && (r_bw2 == '0 || r_bh2 == '0);
        end
    end

    // Stage 4: union = 4*(area a + area b) - intersection.
    always_comb begin
        w_area_sum = {{(DEN_W-AW){1'b0}}, r_aa} + {{(DEN_W-AW){1'b0}}, r_ab};
        w_union    = (w_area_sum << AREA_SHIFT) - {{(DEN_W-NUM_W){1'b0}}, r_inter};
    end

    // A zero union yields a zero ratio: the divider sees 0 / 1.
    always_ff @(posedge i_clk) begin
        if (w_adv4 && r_v3) begin
            r_num <= r_zero3 ? '0 : r_inter;
            r_den <= r_zero3 ? DEN_W'(1) : w_union;
        end
    end

    assign o_frac.valid = r_v4;
    assign o_frac.num   = r_num;
    assign o_frac.den   = r_den;

    // The ratio handed to the divider never exceeds one.
    a_num_le_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_frac.valid |-> ({{(DEN_W-NUM_W){1'b0}}, o_frac.num} <= o_frac.den))
        else $error("biou_geom: intersection exceeds union");

    // The divider is never handed a zero denominator.
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_frac.valid |-> (o_frac.den != '0))
        else $error("biou_geom: zero denominator");

    // A stalled word stays in place until the divider takes it.
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_frac.valid && !o_frac.ready) |=>
            (o_frac.valid && $stable(o_frac.num) && $stable(o_frac.den)))
        else $error("biou_geom: stalled word changed");

endmodule

FILE: hw/rtl/biou_div.sv
// Pipelined restoring divider: one quotient bit per stage, num <= den.
`timescale 1ns / 1ps

module biou_div #(
    parameter int unsigned NUM_W     = 34,
    parameter int unsigned DEN_W     = 35,
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    biou_frac_if.sink     i_frac,
    biou_iou_if.source    o_iou
);
    localparam int unsigned F  = FRAC_BITS;
    localparam int unsigned QW = FRAC_BITS + 1;

    // Stage k holds k+1 quotient bits; the last stage keeps only the quotient.
    logic             r_vld [0:F];
    logic [QW-1:0]    r_quo [0:F];
    logic [DEN_W-1:0] r_rem [0:F-1];
    logic [DEN_W-1:0] r_den [0:F-1];
    logic             w_adv [0:F];

    for (genvar k = 0; k <= F; k++) begin : g_stage
        logic w_in_vld;

        // A stage moves when it is empty or the stage after it moves.
        if (k == F) begin : g_adv_last
            assign w_adv[k] = !r_vld[k] || o_iou.ready;
        end else begin : g_adv_mid
            assign w_adv[k] = !r_vld[k] || w_adv[k+1];
        end

        if (k == 0) begin : g_in0
            assign w_in_vld = i_frac.valid;
        end else begin : g_inx
            assign w_in_vld = r_vld[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (w_adv[k]) begin
                r_vld[k] <= w_in_vld;
            end
        end

        if (k == 0) begin : g_first
            logic [DEN_W-1:0] w_num_ext;
            logic             w_ge;

            // Integer part: one when the intersection equals the union.
            always_comb begin
                w_num_ext = {{(DEN_W-NUM_W){1'b0}}, i_frac.num};
                w_ge      = (w_num_ext >= i_frac.den);
            end

            always_ff @(posedge i_clk) begin
                if (w_adv[k] && w_in_vld) begin
                    r_quo[k] <= {{(QW-1){1'b0}}, w_ge};
                    r_rem[k] <= w_ge ? (w_num_ext - i_frac.den) : w_num_ext;
                    r_den[k] <= i_frac.den;
                end
            end
        end else begin : g_step
            logic [DEN_W:0] w_trial;
            logic           w_ge;

            // Shift the remainder left and test whether the divisor fits.
            always_comb begin
                w_trial = {r_rem[k-1], 1'b0};
                w_ge    = (w_trial >= {1'b0, r_den[k-1]});
            end

            always_ff @(posedge i_clk) begin
                if (w_adv[k] && w_in_vld) begin
                    r_quo[k] <= {r_quo[k-1][QW-2:0], w_ge};
                end
            end

            if (k < F) begin : g_carry
                logic [DEN_W-1:0] w_diff;

                // Where the divisor fits, the difference is below it and fits DEN_W bits.
                assign w_diff = w_trial[DEN_W-1:0] - r_den[k-1];

                always_ff @(posedge i_clk) begin
                    if (w_adv[k] && w_in_vld) begin
                        r_rem[k] <= w_ge ? w_diff : w_trial[DEN_W-1:0];
                        r_den[k] <= r_den[k-1];
                    end
                end

                // Each partial remainder stays below the divisor.
                a_rem_lt_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
                    r_vld[k] |-> (r_rem[k] < r_den[k]))
                    else $error("biou_div: partial remainder not below divisor");
            end
        end
    end

    assign i_frac.ready = w_adv[0];
    assign o_iou.valid  = r_vld[F];
    assign o_iou.iou    = r_quo[F];

    // The ratio never exceeds one, so the result is at most 2^FRAC_BITS.
    a_iou_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_iou.valid |-> (o_iou.iou <= (QW'(1) << F)))
        else $error("biou_div: result above one");

    // A full-scale result carries no fraction bits.
    a_full_exact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_iou.valid && o_iou.iou[F]) |-> (o_iou.iou[F-1:0] == '0))
        else $error("biou_div: integer bit set with nonzero fraction");

endmodule

FILE: hw/rtl/box_iou.sv
// Box intersection over union: geometry front end followed by a bit-per-stage divider.
// Throughput: one pair per cycle while the output is not stalled; the divider has one stage per quotient bit.
// A stalled output holds the pipeline only where it is full; empty stages still fill.
// Reset (synchronous, active low) clears the stage valid bits; no other state is cleared.
`timescale 1ns / 1ps

module box_iou #(
    parameter int unsigned COORD_BITS    = 16,
    parameter int unsigned IOU_FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    biou_pair_if.sink   i_pair,
    biou_iou_if.source  o_iou
);
    import biou_pkg::*;

    localparam int unsigned NUM_W = 2 * COORD_BITS + NUM_XB;
    localparam int unsigned DEN_W = 2 * COORD_BITS + DEN_XB;

    // Link between the geometry stages and the divider.
    biou_frac_if #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_frac ();

    biou_geom #(
        .COORD_BITS (COORD_BITS),
        .NUM_W      (NUM_W),
        .DEN_W      (DEN_W)
    ) u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pair  (i_pair),
        .o_frac  (u_frac)
    );

    biou_div #(
        .NUM_W     (NUM_W),
        .DEN_W     (DEN_W),
        .FRAC_BITS (IOU_FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_frac  (u_frac),
        .o_iou   (o_iou)
    );

endmodule

FILE: tb/tb_box_iou.sv
// Self-checking testbench for the box intersection-over-union pipeline.
`timescale 1ns / 1ps

module tb_box_iou;

    localparam int unsigned COORD_BITS    = 16;
    localparam int unsigned IOU_FRAC_BITS = 16;
    localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

    // One word on the input channel: two boxes as center and size.
    typedef struct packed {
        logic [COORD_BITS-1:0] acx;
        logic [COORD_BITS-1:0] acy;
        logic [COORD_BITS-1:0] aw;
        logic [COORD_BITS-1:0] ah;
        logic [COORD_BITS-1:0] bcx;
        logic [COORD_BITS-1:0] bcy;
        logic [COORD_BITS-1:0] bw;
        logic [COORD_BITS-1:0] bh;
    } t_box_pair;

    logic i_clk;
    logic i_rst_n;
    bit   idle_on;
    int   mismatch_count;

    logic [IOU_FRAC_BITS:0] iou_expected[$];

    biou_pair_if #(.COORD_BITS(COORD_BITS)) pair_bus ();
    biou_iou_if #(.IOU_FRAC_BITS(IOU_FRAC_BITS)) iou_bus ();

    box_iou #(
        .COORD_BITS   (COORD_BITS),
        .IOU_FRAC_BITS(IOU_FRAC_BITS)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pair (pair_bus),
        .o_iou  (iou_bus)
    );

    // Clock with a 20 ns period.
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = ~i_clk;
    end

    // Exact overlap ratio of two boxes, with edges in doubled units.
    function automatic logic [IOU_FRAC_BITS:0] compute_iou(t_box_pair p);
        longint a_lo, a_hi, b_lo, b_hi, hx, vy;
        longint unsigned overlap_area, union_area, quot;
        a_lo = 2 * longint'(p.acx) - longint'(p.aw);
        a_hi = 2 * longint'(p.acx) + longint'(p.aw);
        b_lo = 2 * longint'(p.bcx) - longint'(p.bw);
        b_hi = 2 * longint'(p.bcx) + longint'(p.bw);
        hx = ((a_hi < b_hi) ? a_hi : b_hi) - ((a_lo > b_lo) ? a_lo : b_lo);
        a_lo = 2 * longint'(p.acy) - longint'(p.ah);
        a_hi = 2 * longint'(p.acy) + longint'(p.ah);
        b_lo = 2 * longint'(p.bcy) - longint'(p.bh);
        b_hi = 2 * longint'(p.bcy) + longint'(p.bh);
        vy = ((a_hi < b_hi) ? a_hi : b_hi) - ((a_lo > b_lo) ? a_lo : b_lo);
        if (hx < 0 || vy < 0) begin
            return '0;
        end
        // Box areas are scaled by four to match the doubled edge units.
        overlap_area = longint'(hx) * longint'(vy);
        union_area = 4 * (longint'(p.aw) * longint'(p.ah))
                   + 4 * (longint'(p.bw) * longint'(p.bh)) - overlap_area;
        if (union_area == 0) begin
            return '0;
        end
        quot = (overlap_area << IOU_FRAC_BITS) / union_area;
        return quot[IOU_FRAC_BITS:0];
    endfunction

    // Idle length: mostly none, sometimes short, rarely long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60) begin
            return 0;
        end else if (r < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Value moved randomly around a point and clamped to the field range.
    function automatic logic [COORD_BITS-1:0] jitter(logic [COORD_BITS-1:0] v,
                                                     int unsigned spread);
        int d;
        int s;
        d = int'($urandom_range(0, 2 * spread)) - int'(spread);
        s = int'(v) + d;
        if (s < 0) begin
            s = 0;
        end else if (s > int'(COORD_MAX)) begin
            s = int'(COORD_MAX);
        end
        return s[COORD_BITS-1:0];
    endfunction

    // Box size: extremes, typical small sizes, or anything in range.
    function automatic logic [COORD_BITS-1:0] pick_size();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            return '0;
        end else if (r < 10) begin
            return COORD_MAX;
        end else if (r < 70) begin
            return COORD_BITS'($urandom_range(1, 4095));
        end
        return COORD_BITS'($urandom_range(0, COORD_MAX));
    endfunction

    // Offers one word and returns at the falling edge after it is taken.
    task automatic send_pair(t_box_pair p);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            pair_bus.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pair_bus.a_center_x = p.acx;
        pair_bus.a_center_y = p.acy;
        pair_bus.a_width    = p.aw;
        pair_bus.a_height   = p.ah;
        pair_bus.b_center_x = p.bcx;
        pair_bus.b_center_y = p.bcy;
        pair_bus.b_width    = p.bw;
        pair_bus.b_height   = p.bh;
        pair_bus.valid      = 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pair_bus.ready);
        @(negedge i_clk);
    endtask

    // Result side: random back-pressure, changed at the falling edge.
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        iou_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left != 0) begin
                stall_left--;
                iou_bus.ready = 1'b0;
            end else begin
                stall_left = pick_gap();
                iou_bus.ready = (stall_left == 0);
            end
        end
    end

    // Check each result word, then record the prediction for each accepted pair.
    always @(posedge i_clk) begin
        logic [IOU_FRAC_BITS:0] want;
        if (i_rst_n) begin
            if (iou_bus.valid && iou_bus.ready) begin
                if (iou_expected.size() == 0) begin
                    $error("iou: result word %0d with none expected", iou_bus.iou);
                    mismatch_count++;
                end else begin
                    want = iou_expected.pop_front();
                    if (iou_bus.iou !== want) begin
                        $error("iou: expected %0d, actual %0d", want, iou_bus.iou);
                        mismatch_count++;
                    end
                end
            end
            if (pair_bus.valid && pair_bus.ready) begin
                iou_expected.push_back(compute_iou({pair_bus.a_center_x,
                    pair_bus.a_center_y, pair_bus.a_width, pair_bus.a_height,
                    pair_bus.b_center_x, pair_bus.b_center_y, pair_bus.b_width,
                    pair_bus.b_height}));
            end
        end
    end

    // Field extremes and bit patterns.
    task automatic test_extremes();
        send_pair('0);
        send_pair('1);
        send_pair({COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 64'd0});
        send_pair({64'd0, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX});
        send_pair({8{16'h5555}});
        send_pair({8{16'haaaa}});
        send_pair({{4{16'h5555}}, {4{16'haaaa}}});
        // Centers at zero with a wide box push the low edge below zero.
        send_pair({16'd0, 16'd0, COORD_MAX, COORD_MAX, 16'd0, 16'd0, 16'd300, 16'd300});
        send_pair({16'd0, 16'd0, COORD_MAX, COORD_MAX,
                   COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX});
    endtask

    // Touching, disjoint, nested, degenerate and identical boxes.
    task automatic test_special_cases();
        // Identical boxes give exactly one.
        send_pair({16'd800, 16'd640, 16'd160, 16'd96, 16'd800, 16'd640, 16'd160, 16'd96});
        // Boxes that touch along x or y have no area in common.
        send_pair({16'd100, 16'd100, 16'd40, 16'd40, 16'd140, 16'd100, 16'd40, 16'd40});
        send_pair({16'd100, 16'd100, 16'd40, 16'd40, 16'd100, 16'd140, 16'd40, 16'd40});
        // Disjoint along x, then along y.
        send_pair({16'd100, 16'd100, 16'd40, 16'd40, 16'd500, 16'd100, 16'd40, 16'd40});
        send_pair({16'd100, 16'd900, 16'd40, 16'd40, 16'd100, 16'd100, 16'd40, 16'd40});
        // One box inside the other.
        send_pair({16'd1000, 16'd1000, 16'd400, 16'd400, 16'd1010, 16'd990, 16'd64, 16'd80});
        // Half overlap.
        send_pair({16'd200, 16'd200, 16'd100, 16'd100, 16'd250, 16'd200, 16'd100, 16'd100});
        // A flat box inside a real one: no common area, nonzero union.
        send_pair({16'd500, 16'd500, 16'd0, 16'd100, 16'd500, 16'd500, 16'd200, 16'd200});
        // Two flat boxes: zero union.
        send_pair({16'd500, 16'd500, 16'd0, 16'd100, 16'd500, 16'd500, 16'd0, 16'd50});
        send_pair({16'd700, 16'd300, 16'd0, 16'd0, 16'd700, 16'd300, 16'd0, 16'd0});
        // Identical boxes of the largest size.
        send_pair({16'h8000, 16'h8000, COORD_MAX, COORD_MAX,
                   16'h8000, 16'h8000, COORD_MAX, COORD_MAX});
    endtask

    // Pairs of nearby boxes of similar size, so most of them overlap.
    task automatic test_overlapping_pairs(int unsigned count);
        t_box_pair p;
        for (int unsigned n = 0; n < count; n++) begin
            // A stretch of back-to-back traffic with no stalls.
            idle_on = !(n >= count / 3 && n < count / 3 + 200);
            p.acx = COORD_BITS'($urandom_range(0, COORD_MAX));
            p.acy = COORD_BITS'($urandom_range(0, COORD_MAX));
            p.aw  = pick_size();
            p.ah  = pick_size();
            p.bcx = jitter(p.acx, p.aw / 2 + 1);
            p.bcy = jitter(p.acy, p.ah / 2 + 1);
            p.bw  = jitter(p.aw, p.aw / 2 + 1);
            p.bh  = jitter(p.ah, p.ah / 2 + 1);
            if ($urandom_range(0, 19) == 0) begin
                p.bcx = p.acx;
                p.bcy = p.acy;
                p.bw  = p.aw;
                p.bh  = p.ah;
            end
            send_pair(p);
        end
        idle_on = 1'b1;
    endtask

    // Unrelated boxes over the whole field range.
    task automatic test_random_pairs(int unsigned count);
        t_box_pair p;
        for (int unsigned n = 0; n < count; n++) begin
            p.acx = COORD_BITS'($urandom_range(0, COORD_MAX));
            p.acy = COORD_BITS'($urandom_range(0, COORD_MAX));
            p.aw  = pick_size();
            p.ah  = pick_size();
            p.bcx = COORD_BITS'($urandom_range(0, COORD_MAX));
            p.bcy = COORD_BITS'($urandom_range(0, COORD_MAX));
            p.bw  = pick_size();
            p.bh  = pick_size();
            send_pair(p);
        end
    endtask

    // Sequence of tests, drain and verdict.
    initial begin
        mismatch_count = 0;
        idle_on = 1'b1;
        i_rst_n = 1'b0;
        pair_bus.valid      = 1'b0;
        pair_bus.a_center_x = '0;
        pair_bus.a_center_y = '0;
        pair_bus.a_width    = '0;
        pair_bus.a_height   = '0;
        pair_bus.b_center_x = '0;
        pair_bus.b_center_y = '0;
        pair_bus.b_width    = '0;
        pair_bus.b_height   = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_extremes();
        test_special_cases();
        test_overlapping_pairs(1200);
        test_random_pairs(600);
        pair_bus.valid = 1'b0;

        while (iou_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (IOU_FRAC_BITS + 10) @(posedge i_clk);
        if (mismatch_count == 0 && iou_expected.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog for a hung pipeline.
    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
